/* hdl/ycr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycr_pkg
// Shared types and constants for the YCgCo-R residual thresholder.
// ----------------------------------------------------------------------------
package ycr_pkg;

	localparam int ADDR_W = 3;
	localparam int COMPLEX_MAX = 6;
	localparam int THR_W = 3;
	localparam int ERR_W = 11;
	localparam int TOTAL_W = 32;

	typedef enum logic [1:0] {
		QM_LOSSLESS   = 2'd0,
		QM_ADAPTIVE   = 2'd1,
		QM_AGGRESSIVE = 2'd2
	} quality_mode_t;

	localparam logic [1:0] QM_RESET = QM_ADAPTIVE;
	localparam logic REG_QUALITY_MODE = 1'b0;

	localparam logic [THR_W-1:0] THRESH_TABLE [COMPLEX_MAX+1] =
		'{3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd4};
	localparam logic [THR_W-1:0] THRESH_HIGH = 3'd4;
	localparam logic [THR_W-1:0] THRESH_NONE = 3'd0;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t       orig;
		rgb_t       base;
		logic [7:0] complexity;
	} pix_t;

	typedef struct packed {
		logic signed [7:0] luma;
		logic signed [7:0] green_chroma;
		logic signed [7:0] orange_chroma;
		logic [THR_W-1:0]  thr;
		logic [1:0]        zeroed;
		logic [ERR_W-1:0]  err;
	} resid_t;

endpackage

/* hdl/ycr_pix_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycr_pix_if
// Pixel input channel: original and base RGB, tile complexity, first flag.
// ----------------------------------------------------------------------------
interface ycr_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] orig_red;
	logic [7:0] orig_green;
	logic [7:0] orig_blue;
	logic [7:0] base_red;
	logic [7:0] base_green;
	logic [7:0] base_blue;
	logic [7:0] tile_complexity;
	logic       first_pixel;

	modport source (
		output valid, orig_red, orig_green, orig_blue,
		output base_red, base_green, base_blue, tile_complexity, first_pixel,
		input  ready
	);

	modport sink (
		input  valid, orig_red, orig_green, orig_blue,
		input  base_red, base_green, base_blue, tile_complexity, first_pixel,
		output ready
	);
endinterface

/* hdl/ycr_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycr_res_if
// Residual output channel: thresholded residuals and running statistics.
// ----------------------------------------------------------------------------
interface ycr_res_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] res_luma;
	logic signed [7:0] res_green_chroma;
	logic signed [7:0] res_orange_chroma;
	logic [2:0]        applied_threshold;
	logic [1:0]        zeroed_here;
	logic [31:0]       zeroed_running;
	logic [10:0]       max_exact_error;
	logic [10:0]       max_lossy_error;

	modport source (
		output valid, res_luma, res_green_chroma, res_orange_chroma,
		output applied_threshold, zeroed_here, zeroed_running,
		output max_exact_error, max_lossy_error,
		input  ready
	);

	modport sink (
		input  valid, res_luma, res_green_chroma, res_orange_chroma,
		input  applied_threshold, zeroed_here, zeroed_running,
		input  max_exact_error, max_lossy_error,
		output ready
	);
endinterface

/* hdl/ycr_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycr_apb_regs
// APB register file holding the quality mode.
// ----------------------------------------------------------------------------
module ycr_apb_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ycr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output logic [1:0]                quality_mode
);
	import ycr_pkg::*;

	logic [1:0] quality_mode_q;
	logic       wr_en;
	logic       sel_mode;

	assign sel_mode = (paddr[ADDR_W-1] == REG_QUALITY_MODE);
	assign wr_en    = psel && penable && pwrite;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quality_mode_q <= QM_RESET;
		end else if (wr_en && sel_mode) begin
			quality_mode_q <= pwdata[1:0];
		end
	end

	assign prdata       = sel_mode ? {30'd0, quality_mode_q} : 32'd0;
	assign quality_mode = quality_mode_q;

endmodule

/* hdl/ycr_residual.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycr_residual
// YCgCo-R transform of both pixels, difference, dead-zone and saturation.
// ----------------------------------------------------------------------------
module ycr_residual (
	input  ycr_pkg::pix_t   pix,
	input  logic [1:0]      quality_mode,
	output ycr_pkg::resid_t res
);
	import ycr_pkg::*;

	// order: Y, Cg, Co
	function automatic logic [29:0] to_ycgco(input rgb_t c);
		logic signed [9:0] r;
		logic signed [9:0] g;
		logic signed [9:0] b;
		logic signed [9:0] co;
		logic signed [9:0] t;
		logic signed [9:0] cg;
		logic signed [9:0] y;
		r  = signed'({2'b00, c.red});
		g  = signed'({2'b00, c.green});
		b  = signed'({2'b00, c.blue});
		co = r - b;
		t  = b + (co >>> 1);
		cg = g - t;
		y  = t + (cg >>> 1);
		return {y, cg, co};
	endfunction

	logic [29:0]          oy;
	logic [29:0]          by;
	logic [2:0]           nc;
	logic [THR_W-1:0]     thr;
	logic signed [10:0]   d [3];
	logic signed [10:0]   k [3];
	logic [9:0]           m [3];
	logic                 z [3];
	logic signed [7:0]    s [3];

	assign oy = to_ycgco(pix.orig);
	assign by = to_ycgco(pix.base);

	assign nc = (pix.complexity > 8'(COMPLEX_MAX)) ? 3'(COMPLEX_MAX) : pix.complexity[2:0];

	always_comb begin
		case (quality_mode)
			QM_LOSSLESS: thr = THRESH_NONE;
			QM_ADAPTIVE: thr = THRESH_TABLE[nc];
			default:     thr = (nc <= 3'd2) ? THRESH_NONE : THRESH_HIGH;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i] = 11'(signed'(oy[29-10*i -: 10])) - 11'(signed'(by[29-10*i -: 10]));
			m[i] = d[i][10] ? 10'(-d[i]) : d[i][9:0];
			z[i] = (m[i] <= {7'd0, thr});
			k[i] = z[i] ? 11'sd0 : d[i];
			if (k[i] < -11'sd128) begin
				s[i] = -8'sd128;
			end else if (k[i] > 11'sd127) begin
				s[i] = 8'sd127;
			end else begin
				s[i] = k[i][7:0];
			end
		end
	end

	always_comb begin
		res.luma          = s[0];
		res.green_chroma  = s[1];
		res.orange_chroma = s[2];
		res.thr           = thr;
		res.zeroed        = 2'(z[0]) + 2'(z[1]) + 2'(z[2]);
		res.err           = (z[0] ? 11'd0 : {1'b0, m[0]})
		                  + (z[1] ? 11'd0 : {1'b0, m[1]})
		                  + (z[2] ? 11'd0 : {1'b0, m[2]});
	end

endmodule

/* hdl/ycgco_residual_thresholder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycgco_residual_thresholder
// YCgCo-R residual dead-zone quantizer with running error statistics.
// ----------------------------------------------------------------------------
// Usage:
//   pix  : valid/ready input channel, one pixel per transfer (original RGB,
//          decoded base RGB, tile complexity, first_pixel flag).
//   res  : valid/ready output channel, one result per pixel.
//   APB  : quality_mode at address 0; the user must write it only while the
//          block is idle, which the block itself does not enforce.
// Path: a transfer fills the input register, then the result register raises
//   res.valid; transform, dead zone and statistics update sit between them.
// Throughput: one pixel per cycle while res.ready stays high.
// Stall: with res.ready low the result register holds, the input register
//   takes one more pixel, then pix.ready drops until the result is taken.
// Reset: arst_n clears both valid flags and all statistics; quality_mode
//   returns to the adaptive table setting.
// ----------------------------------------------------------------------------
module ycgco_residual_thresholder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ycr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	ycr_pix_if.sink                    pix,
	ycr_res_if.source                  res
);
	import ycr_pkg::*;

	logic [1:0]           quality_mode;
	logic                 v_s1;
	pix_t                 pix_s1;
	logic                 first_s1;
	logic                 adv_s1;
	logic                 v_s2;
	resid_t               core;
	resid_t               res_s2;
	logic [TOTAL_W-1:0]   zeroed_total_q;
	logic [ERR_W-1:0]     max_exact_q;
	logic [ERR_W-1:0]     max_lossy_q;
	logic [TOTAL_W-1:0]   total_base;
	logic [TOTAL_W:0]     total_sum;
	logic [ERR_W-1:0]     exact_base;
	logic [ERR_W-1:0]     lossy_base;

	ycr_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.quality_mode (quality_mode)
	);

	ycr_residual u_resid (
		.pix          (pix_s1),
		.quality_mode (quality_mode),
		.res          (core)
	);

	assign adv_s1    = v_s1 && (!v_s2 || res.ready);
	assign pix.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix.ready) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			pix_s1.orig.red   <= pix.orig_red;
			pix_s1.orig.green <= pix.orig_green;
			pix_s1.orig.blue  <= pix.orig_blue;
			pix_s1.base.red   <= pix.base_red;
			pix_s1.base.green <= pix.base_green;
			pix_s1.base.blue  <= pix.base_blue;
			pix_s1.complexity <= pix.tile_complexity;
			first_s1          <= pix.first_pixel;
		end
	end

	// statistics, cleared ahead of a first pixel
	assign total_base = first_s1 ? '0 : zeroed_total_q;
	assign exact_base = first_s1 ? '0 : max_exact_q;
	assign lossy_base = first_s1 ? '0 : max_lossy_q;
	assign total_sum  = {1'b0, total_base} + (TOTAL_W+1)'(core.zeroed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2           <= 1'b0;
			zeroed_total_q <= '0;
			max_exact_q    <= '0;
			max_lossy_q    <= '0;
		end else begin
			if (adv_s1) begin
				v_s2           <= 1'b1;
				zeroed_total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
				if (core.thr == THRESH_NONE) begin
					max_exact_q <= (core.err > exact_base) ? core.err : exact_base;
					max_lossy_q <= lossy_base;
				end else begin
					max_exact_q <= exact_base;
					max_lossy_q <= (core.err > lossy_base) ? core.err : lossy_base;
				end
			end else if (res.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= core;
		end
	end

	assign res.valid             = v_s2;
	assign res.res_luma          = res_s2.luma;
	assign res.res_green_chroma  = res_s2.green_chroma;
	assign res.res_orange_chroma = res_s2.orange_chroma;
	assign res.applied_threshold = res_s2.thr;
	assign res.zeroed_here       = res_s2.zeroed;
	assign res.zeroed_running    = zeroed_total_q;
	assign res.max_exact_error   = max_exact_q;
	assign res.max_lossy_error   = max_lossy_q;

`ifndef ASSERT_OFF
	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |-> !pix.ready)
		else $error("input register overwritten while held");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !first_s1) |=> (zeroed_total_q >= $past(zeroed_total_q)))
		else $error("zeroed total decreased without a first pixel");

	a_first_exact_clears_lossy: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && first_s1 && core.thr == THRESH_NONE) |=> (max_lossy_q == '0))
		else $error("lossy maximum not cleared by first pixel");

	a_lossless_no_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && quality_mode == QM_LOSSLESS) |-> (res_s2.thr == THRESH_NONE))
		else $error("nonzero threshold in lossless mode");
`endif

endmodule
